[sv/srfp_pkg.sv]
`default_nettype none
package srfp_pkg;

  // frame framing bytes
  localparam logic [7:0] TAIL_BYTE  = 8'h6B;
  localparam logic [7:0] CMD_POS    = 8'h36;
  localparam logic [7:0] CMD_STATUS = 8'h3A;

  // frame lengths in bytes
  localparam logic [3:0] LEN_STATUS = 4'd4;
  localparam logic [3:0] LEN_POS    = 4'd8;
  localparam logic [3:0] LEN_MAX    = 4'd8;

  // bytes kept for decode: address, command, sign or status, four count bytes
  localparam int unsigned STORE_DEPTH = 7;

  // status byte bit positions
  localparam int unsigned ST_ENABLED    = 0;
  localparam int unsigned ST_REACHED    = 1;
  localparam int unsigned ST_STALL      = 2;
  localparam int unsigned ST_STALL_PROT = 3;
  localparam int unsigned ST_LEFT_LIM   = 4;
  localparam int unsigned ST_RIGHT_LIM  = 5;
  localparam int unsigned ST_BIT_SEVEN  = 7;

  typedef enum logic [0:0] {
    KIND_STATUS = 1'b0,
    KIND_POS    = 1'b1
  } frame_kind_e;

  // one decoded frame
  typedef struct packed {
    frame_kind_e frame_kind;
    logic [7:0]  motor_addr;
    logic [7:0]  status_raw;
    logic        enabled_flag;
    logic        reached_flag;
    logic        stall_flag;
    logic        stall_protect_flag;
    logic        left_limit_flag;
    logic        right_limit_flag;
    logic        bit_seven_flag;
    logic        pos_negative;
    logic [31:0] pos_count;
  } result_t;

  // assembler state seen from outside
  typedef struct packed {
    logic [3:0] byte_count;
    logic [3:0] expected_length;
  } asm_status_t;

endpackage
`default_nettype wire

[sv/stepper_reply_frame_parser.sv]
`default_nettype none
// Reply frame parser for a stepper driver's UART stream. Each input item is
// one received byte; frames are address, command, payload, tail 0x6B. Command
// 0x3A gives a 4-byte status frame, 0x36 an 8-byte position frame; any other
// command drops the two bytes taken. A frame with a bad tail is dropped with
// no result. A good frame gives one result item, passing through the input
// register and then the result register after its tail byte is accepted. One
// byte is taken every cycle; the only stall is a result held on the output side.
module stepper_reply_frame_parser (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // [7:0] rx_byte
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // [7:0] motor_addr, [15:8] status_raw, [16] enabled_flag, [17] reached_flag,
  // [18] stall_flag, [19] stall_protect_flag, [20] left_limit_flag,
  // [21] right_limit_flag, [22] bit_seven_flag, [23] pos_negative,
  // [55:24] pos_count
  output logic [55:0]      m_axis_tdata_o,
  output logic             m_axis_tuser_o    // [0] frame_kind
);

  logic                  stall;
  logic                  in_valid;
  logic [7:0]            in_byte;
  logic                  step;
  logic                  res_valid;
  srfp_pkg::result_t     res, out_res;
  srfp_pkg::asm_status_t stat;

  // the held result blocks the pipe only while not taken
  assign stall = m_axis_tvalid_o && !m_axis_tready_i;
  assign step  = in_valid && !stall;

  srfp_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tready_o (s_axis_tready_o),
    .s_tdata_i  (s_axis_tdata_i),
    .stall_i    (stall),
    .valid_o    (in_valid),
    .byte_o     (in_byte)
  );

  srfp_assembler u_asm (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .byte_i      (in_byte),
    .res_valid_o (res_valid),
    .res_o       (res),
    .stat_o      (stat)
  );

  srfp_out_stage u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (res_valid),
    .res_i      (res),
    .m_tready_i (m_axis_tready_i),
    .m_tvalid_o (m_axis_tvalid_o),
    .res_o      (out_res)
  );

  // pack the result item
  assign m_axis_tuser_o = out_res.frame_kind;
  assign m_axis_tdata_o = {out_res.pos_count,
                           out_res.pos_negative,
                           out_res.bit_seven_flag,
                           out_res.right_limit_flag,
                           out_res.left_limit_flag,
                           out_res.stall_protect_flag,
                           out_res.stall_flag,
                           out_res.reached_flag,
                           out_res.enabled_flag,
                           out_res.status_raw,
                           out_res.motor_addr};

  // byte count stays inside the longest frame
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.byte_count < srfp_pkg::LEN_MAX)
    else $error("byte count out of range");

  // past the command byte a valid length is always held
  a_len_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stat.byte_count >= 4'd2) |->
      (stat.expected_length == srfp_pkg::LEN_STATUS ||
       stat.expected_length == srfp_pkg::LEN_POS))
    else $error("no frame length held past command byte");

  // a new result follows a completed frame
  a_result_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !$past(m_axis_tvalid_o)) |->
      $past(step && (stat.byte_count + 4'd1 == stat.expected_length) &&
            in_byte == srfp_pkg::TAIL_BYTE))
    else $error("result without a completed frame");

  // a frame can only complete once the previous result can move
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall |-> !res_valid)
    else $error("result produced while output stalled");

endmodule
`default_nettype wire

[sv/srfp_in_stage.sv]
`default_nettype none
module srfp_in_stage (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_tvalid_i,
  output logic            s_tready_o,
  input  wire logic [7:0] s_tdata_i,
  input  wire logic       stall_i,
  output logic            valid_o,
  output logic [7:0]      byte_o
);

  logic       valid_q, valid_d;
  logic [7:0] byte_q, byte_d;
  logic       take;

  // accept when the stage is empty or the held item moves on this cycle
  assign s_tready_o = !valid_q || !stall_i;
  assign take       = s_tvalid_i && s_tready_o;

  always_comb begin
    valid_d = valid_q;
    byte_d  = byte_q;
    if (take) begin
      valid_d = 1'b1;
      byte_d  = s_tdata_i;
    end else if (!stall_i) begin
      valid_d = 1'b0;
    end
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;

endmodule
`default_nettype wire

[sv/srfp_assembler.sv]
`default_nettype none
module srfp_assembler (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           step_i,
  input  wire logic [7:0]     byte_i,
  output logic                res_valid_o,
  output srfp_pkg::result_t   res_o,
  output srfp_pkg::asm_status_t stat_o
);

  logic [3:0] count_q, count_d;
  logic [3:0] exp_q, exp_d;
  logic [7:0] store_q [srfp_pkg::STORE_DEPTH];
  logic [3:0] count_eff, exp_eff, count_nxt;
  logic       len_ok;
  logic       done;

  // a count at or past the longest frame length restarts at byte 0
  assign count_eff = (count_q >= srfp_pkg::LEN_MAX) ? 4'd0 : count_q;
  assign exp_eff   = (count_q >= srfp_pkg::LEN_MAX) ? 4'd0 : exp_q;
  assign count_nxt = count_eff + 4'd1;
  assign len_ok    = (exp_eff == srfp_pkg::LEN_STATUS) || (exp_eff == srfp_pkg::LEN_POS);

  // next count and expected length
  always_comb begin
    count_d = count_q;
    exp_d   = exp_q;
    done    = 1'b0;
    if (step_i) begin
      count_d = count_nxt;
      exp_d   = exp_eff;
      if (count_nxt == 4'd2) begin
        if (byte_i == srfp_pkg::CMD_STATUS) begin
          exp_d = srfp_pkg::LEN_STATUS;
        end else if (byte_i == srfp_pkg::CMD_POS) begin
          exp_d = srfp_pkg::LEN_POS;
        end else begin
          count_d = 4'd0;
          exp_d   = 4'd0;
        end
      end else if (count_nxt != 4'd1) begin
        if (!len_ok) begin
          count_d = 4'd0;
          exp_d   = 4'd0;
        end else if (count_nxt >= exp_eff) begin
          count_d = 4'd0;
          exp_d   = 4'd0;
          done    = 1'b1;
        end
      end
    end
  end

  // the tail is the byte arriving as the frame completes
  assign res_valid_o = done && (byte_i == srfp_pkg::TAIL_BYTE);

  // decode from the stored frame bytes
  always_comb begin
    res_o            = '0;
    res_o.motor_addr = store_q[0];
    if (exp_eff == srfp_pkg::LEN_POS) begin
      res_o.frame_kind   = srfp_pkg::KIND_POS;
      res_o.pos_negative = (store_q[2] != 8'd0);
      res_o.pos_count    = {store_q[3], store_q[4], store_q[5], store_q[6]};
    end else begin
      res_o.frame_kind         = srfp_pkg::KIND_STATUS;
      res_o.status_raw         = store_q[2];
      res_o.enabled_flag       = store_q[2][srfp_pkg::ST_ENABLED];
      res_o.reached_flag       = store_q[2][srfp_pkg::ST_REACHED];
      res_o.stall_flag         = store_q[2][srfp_pkg::ST_STALL];
      res_o.stall_protect_flag = store_q[2][srfp_pkg::ST_STALL_PROT];
      res_o.left_limit_flag    = store_q[2][srfp_pkg::ST_LEFT_LIM];
      res_o.right_limit_flag   = store_q[2][srfp_pkg::ST_RIGHT_LIM];
      res_o.bit_seven_flag     = store_q[2][srfp_pkg::ST_BIT_SEVEN];
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 4'd0;
      exp_q   <= 4'd0;
    end else begin
      count_q <= count_d;
      exp_q   <= exp_d;
    end
  end

  // frame bytes, the tail byte of a position frame is never kept
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < srfp_pkg::STORE_DEPTH; i++) begin
      if (step_i && (count_eff == 4'(i))) begin
        store_q[i] <= byte_i;
      end
    end
  end

  assign stat_o.byte_count      = count_q;
  assign stat_o.expected_length = exp_q;

endmodule
`default_nettype wire

[sv/srfp_out_stage.sv]
`default_nettype none
module srfp_out_stage (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              load_i,
  input  wire srfp_pkg::result_t res_i,
  input  wire logic              m_tready_i,
  output logic                   m_tvalid_o,
  output srfp_pkg::result_t      res_o
);

  logic              valid_q, valid_d;
  srfp_pkg::result_t res_q, res_d;

  always_comb begin
    valid_d = valid_q;
    res_d   = res_q;
    if (load_i) begin
      valid_d = 1'b1;
      res_d   = res_i;
    end else if (m_tready_i) begin
      valid_d = 1'b0;
    end
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign m_tvalid_o = valid_q;
  assign res_o      = res_q;

endmodule
`default_nettype wire
